FILE: rtl/hbls_pkg.sv
// ----------------------------------------------------------------------------
// hbls_pkg - shared types and constants of the heartbeat link session core
// Slot state word, stream word layouts, register indexes and the send period
// helper used by the session core.
// ----------------------------------------------------------------------------
package hbls_pkg;

  localparam int MAX_SESSIONS = 4;
  localparam int IDX_W        = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int SLOT_W       = 2;
  localparam int SLOT_XW      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam int IN_TDATA_W   = 152;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 232;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 20;

  typedef logic [IDX_W-1:0] idx_t;

  // item kinds
  localparam logic [1:0] KIND_TIME  = 2'd0;
  localparam logic [1:0] KIND_SEND  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // session modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_BONDING = 2'd1;
  localparam logic [1:0] MODE_BONDED  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PERIOD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOND_RETRY = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MISSED     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_JITTER     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOND_CODE  = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] peer_window;
    logic [47:0] last_send_time;
    logic [47:0] last_reply_time;
    logic [47:0] last_bond_time;
    logic [31:0] tx_counter;
    logic [31:0] rx_counter;
    logic [31:0] rx_stamp;
    logic [7:0]  reply_type;
    logic [31:0] replies_seen;
    logic [31:0] failures_seen;
    logic [31:0] rebonds_seen;
  } entry_t;

  // input word, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] reply_window_ms;
    logic [7:0]  reply_message;
    logic [31:0] reply_stamp;
    logic [31:0] reply_counter;
    logic        checksum_ok;
    logic        source_match;
    logic        send_ok;
    logic [7:0]  verdict;
    logic [47:0] now_ms;
    logic [1:0]  slot;
  } in_word_t;

  // result word, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] rebond_count;
    logic [31:0] send_fail_count;
    logic [31:0] reply_count;
    logic [7:0]  last_message;
    logic        rebonded;
    logic [15:0] send_period_ms;
    logic [31:0] ack_stamp;
    logic [31:0] ack_counter;
    logic [31:0] next_counter;
    logic [7:0]  message_type;
    logic        send_due;
    logic [1:0]  session_state;
  } out_word_t;

  typedef struct packed {
    logic [15:0] min_period;
    logic [15:0] max_period;
    logic [15:0] bond_retry;
    logic [7:0]  missed;
    logic [15:0] jitter;
    logic [19:0] floor_ms;
    logic [7:0]  bond_code;
  } cfg_t;

  // half the window, min bound first, max bound wins; a zero window gives the min bound
  function automatic logic [15:0] period_of(input logic [15:0] win,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] p;
    if (win == 16'd0) begin
      p = lo;
    end else begin
      p = {1'b0, win[15:1]};
      if (p < lo) p = lo;
      if (p > hi) p = hi;
    end
    return p;
  endfunction

  function automatic idx_t slot_idx(input logic [SLOT_W-1:0] slot);
    logic [SLOT_XW-1:0] t;
    t = SLOT_XW'(slot);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
    logic [SLOT_XW-1:0] t;
    t = SLOT_XW'(slot);
    return (int'(t) < MAX_SESSIONS);
  endfunction

endpackage

FILE: rtl/hbls_state_mem.sv
// ----------------------------------------------------------------------------
// hbls_state_mem - per-slot session state memory
// Registered synchronous read, one write port, valid bits for reset-to-zero
// and a bypass of the last written entry.
// ----------------------------------------------------------------------------
module hbls_state_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  hbls_pkg::idx_t   rd_idx,
  input  logic             wr_en,
  input  hbls_pkg::idx_t   wr_idx,
  input  hbls_pkg::entry_t wr_data,
  output hbls_pkg::entry_t rd_data
);
  import hbls_pkg::*;

  entry_t                  mem_r [MAX_SESSIONS];
  logic [MAX_SESSIONS-1:0] vld_r;
  entry_t                  rdq_r;
  idx_t                    rdidx_r;
  logic                    rdv_r;
  entry_t                  fwd_r;
  idx_t                    fwd_idx_r;
  logic                    fwd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdq_r   <= mem_r[rd_idx];
      rdidx_r <= rd_idx;
    end
    if (wr_en) begin
      fwd_r     <= wr_data;
      fwd_idx_r <= wr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rdv_r   <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
        fwd_v_r       <= 1'b1;
      end
      if (rd_en) begin
        rdv_r <= vld_r[rd_idx];
      end
    end
  end

  // last write to a slot is its current contents, so bypass on a match
  always_comb begin
    if (fwd_v_r && fwd_idx_r == rdidx_r) begin
      rd_data = fwd_r;
    end else if (rdv_r) begin
      rd_data = rdq_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: rtl/heartbeat_link_session_core.sv
// ----------------------------------------------------------------------------
// heartbeat_link_session_core - per-slot heartbeat session tracker
// Keeps idle / bonding / bonded state for each slot and reports send timing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per event (time check, send outcome, received reply),
//           kind on in_tuser, slot and event fields on in_tdata.
//   out_* : one result word per input word, in order.
//   cfg_* : register writes, only while the core is idle.
// Pipeline: a result becomes valid once its accepted word has passed the
//   state read at the accepting edge, the elapsed/limit prep and the update
//   into the output register.
// Throughput: one word per cycle while consecutive words name different
//   slots and the output is not stalled; a word for the same slot as the
//   word just accepted waits until that word has moved on from stage 1.
//   The wait is set by the registered read of the state memory.
// Reset: all slots read as idle with zeroed state at once (valid bits),
//   registers return to their defaults.
// Stall: when out_tready is low with a result valid, the result is held and
//   the whole pipe freezes; in_tready drops until the output register drains.
// ----------------------------------------------------------------------------
module heartbeat_link_session_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // slot, now_ms, verdict, send_ok, source_match, checksum_ok, reply_counter,
  // reply_stamp, reply_message, reply_window_ms, zero pad
  input  logic [hbls_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind
  input  logic [hbls_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // session_state, send_due, message_type, next_counter, ack_counter,
  // ack_stamp, send_period_ms, rebonded, last_message, reply_count,
  // send_fail_count, rebond_count, zero pad
  output logic [hbls_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [hbls_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hbls_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hbls_pkg::*;

  cfg_t       cfg_r;
  in_word_t   in_word;
  logic       adv;
  logic       acc;

  logic       s1_v_r;
  in_word_t   s1_word_r;
  logic [1:0] s1_kind_r;
  entry_t     s1_ent;
  logic [23:0] s1_prod;

  logic        s2_v_r;
  in_word_t    s2_word_r;
  logic [1:0]  s2_kind_r;
  entry_t      s2_ent_r;
  logic [23:0] s2_prod_r;
  logic [47:0] s2_el_reply_r;
  logic [47:0] s2_el_bond_r;
  logic [47:0] s2_el_send_r;

  entry_t      upd;
  logic        due;
  logic        reb;
  logic [24:0] lim_raw;
  logic [24:0] lim;
  logic        s2_in_range;
  logic        wr_en;
  out_word_t   res;
  out_word_t   out_word_r;
  logic        out_tvalid_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period <= 16'd50;
      cfg_r.max_period <= 16'd1000;
      cfg_r.bond_retry <= 16'd500;
      cfg_r.missed     <= 8'd3;
      cfg_r.jitter     <= 16'd100;
      cfg_r.floor_ms   <= 20'd1000;
      cfg_r.bond_code  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_PERIOD: cfg_r.min_period <= cfg_wdata[15:0];
        CFG_MAX_PERIOD: cfg_r.max_period <= cfg_wdata[15:0];
        CFG_BOND_RETRY: cfg_r.bond_retry <= cfg_wdata[15:0];
        CFG_MISSED:     cfg_r.missed     <= cfg_wdata[7:0];
        CFG_JITTER:     cfg_r.jitter     <= cfg_wdata[15:0];
        CFG_FLOOR:      cfg_r.floor_ms   <= cfg_wdata;
        CFG_BOND_CODE:  cfg_r.bond_code  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- input and interlock ----------------
  assign in_word = in_word_t'(in_tdata);
  assign adv     = !out_tvalid_r || out_tready;
  // a word for the slot sitting in stage 1 waits until that word moves on to stage 2
  assign in_tready = adv && !(s1_v_r && s1_word_r.slot == in_word.slot);
  assign acc       = in_tvalid && in_tready;

  hbls_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_idx  (slot_idx(in_word.slot)),
    .wr_en   (wr_en),
    .wr_idx  (slot_idx(s2_word_r.slot)),
    .wr_data (upd),
    .rd_data (s1_ent)
  );

  // ---------------- stage 1: state read, elapsed times, window product ----
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_word_r <= in_word;
      s1_kind_r <= in_tuser;
    end
  end

  assign s1_prod = 24'(s1_ent.peer_window) * 24'(cfg_r.missed);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_word_r     <= s1_word_r;
      s2_kind_r     <= s1_kind_r;
      s2_ent_r      <= s1_ent;
      s2_prod_r     <= s1_prod;
      s2_el_reply_r <= s1_word_r.now_ms - s1_ent.last_reply_time;
      s2_el_bond_r  <= s1_word_r.now_ms - s1_ent.last_bond_time;
      s2_el_send_r  <= s1_word_r.now_ms - s1_ent.last_send_time;
    end
  end

  // ---------------- stage 2: update and result ----------------
  assign s2_in_range = slot_in_range(s2_word_r.slot);
  assign lim_raw     = 25'(s2_prod_r) + 25'(cfg_r.jitter);
  assign lim         = (lim_raw < 25'(cfg_r.floor_ms)) ? 25'(cfg_r.floor_ms) : lim_raw;

  always_comb begin
    upd = s2_ent_r;
    due = 1'b0;
    reb = 1'b0;
    case (s2_kind_r)
      KIND_TIME: begin
        if (s2_ent_r.mode == MODE_BONDED && s2_el_reply_r >= 48'(lim)) begin
          upd.mode         = MODE_IDLE;
          upd.peer_window  = 16'd0;
          upd.tx_counter   = 32'd0;
          upd.rx_counter   = 32'd0;
          upd.rx_stamp     = 32'd0;
          upd.rebonds_seen = s2_ent_r.rebonds_seen + 32'd1;
          reb              = 1'b1;
        end
        if (upd.mode == MODE_BONDING) begin
          due = (s2_el_bond_r >= 48'(cfg_r.bond_retry));
        end else if (upd.mode == MODE_IDLE) begin
          due = 1'b1;
        end else begin
          due = (s2_el_send_r >=
                 48'(period_of(upd.peer_window, cfg_r.min_period, cfg_r.max_period)));
        end
      end
      KIND_SEND: begin
        if (s2_word_r.send_ok) begin
          upd.tx_counter     = s2_ent_r.tx_counter + 32'd1;
          upd.last_send_time = s2_word_r.now_ms;
          if (s2_ent_r.mode == MODE_IDLE) begin
            upd.mode           = MODE_BONDING;
            upd.last_bond_time = s2_word_r.now_ms;
          end else if (s2_ent_r.mode == MODE_BONDING) begin
            upd.last_bond_time = s2_word_r.now_ms;
          end
        end else begin
          upd.failures_seen = s2_ent_r.failures_seen + 32'd1;
        end
      end
      KIND_REPLY: begin
        if (s2_word_r.source_match && s2_word_r.checksum_ok) begin
          upd.rx_counter      = s2_word_r.reply_counter;
          upd.rx_stamp        = s2_word_r.reply_stamp;
          upd.last_reply_time = s2_word_r.now_ms;
          upd.reply_type      = s2_word_r.reply_message;
          upd.replies_seen    = s2_ent_r.replies_seen + 32'd1;
          if (s2_word_r.reply_window_ms != 16'd0) begin
            upd.peer_window = s2_word_r.reply_window_ms;
          end
          upd.mode = MODE_BONDED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    if (s2_in_range) begin
      res.session_state   = upd.mode;
      res.send_due        = due;
      res.message_type    = (upd.mode == MODE_BONDED) ? s2_word_r.verdict : cfg_r.bond_code;
      res.next_counter    = upd.tx_counter + 32'd1;
      res.ack_counter     = upd.rx_counter;
      res.ack_stamp       = upd.rx_stamp;
      res.send_period_ms  = period_of(upd.peer_window, cfg_r.min_period, cfg_r.max_period);
      res.rebonded        = reb;
      res.last_message    = upd.reply_type;
      res.reply_count     = upd.replies_seen;
      res.send_fail_count = upd.failures_seen;
      res.rebond_count    = upd.rebonds_seen;
    end else begin
      res.send_period_ms  = cfg_r.min_period;
    end
  end

  assign wr_en = adv && s2_v_r && s2_in_range;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r       <= acc;
      s2_v_r       <= s1_v_r;
      out_tvalid_r <= s2_v_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_word_r;

`ifndef SYNTHESIS
  // the words in stage 1 and stage 2 never share a slot, the bypass relies on it
  a_no_slot_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r) |-> (s1_word_r.slot != s2_word_r.slot))
    else $error("stage 1 and stage 2 hold the same slot");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (s1_v_r && s1_word_r.slot == $past(in_word.slot)))
    else $error("accepted word missing from stage 1");

  a_rebond_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_word_r.rebonded) |-> (out_word_r.session_state == MODE_IDLE))
    else $error("re-bond reported on a slot that is not idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !adv) |=> (s2_v_r && $stable(s2_word_r.slot)))
    else $error("stage 2 moved during a stall");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - heartbeat link session core
// Streams time checks, send outcomes and reply words through the core under
// several register settings and compares every result word, field by field,
// against a cycle-free model of the per-slot session state kept here.
// ----------------------------------------------------------------------------
module testbench;
  import hbls_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam logic [47:0] WRAP_TOP = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0] kind;
    in_word_t   word;
  } event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  event_t    event_words[$];
  out_word_t session_reports[$];
  entry_t    sessions [MAX_SESSIONS];
  cfg_t      cfg_shadow;

  logic        steady = 1'b0;
  logic [47:0] clock_ms;
  int in_gap = 0;
  int out_stall = 0;
  int stalled_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int reports_checked = 0;
  int settings_applied = 0;
  int rebonds_expected = 0;
  int dues_expected = 0;

  heartbeat_link_session_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] clamped_period(input logic [15:0] win);
    logic [15:0] p;
    if (win == 16'd0) begin
      return cfg_shadow.min_period;
    end
    p = win >> 1;
    if (p < cfg_shadow.min_period) p = cfg_shadow.min_period;
    if (p > cfg_shadow.max_period) p = cfg_shadow.max_period;
    return p;
  endfunction

  // applies one word to the slot model and returns the report it should give
  function automatic out_word_t advance_session(input logic [1:0] kind, input in_word_t w);
    entry_t      e;
    out_word_t   r;
    logic [47:0] since;
    logic [63:0] limit;
    logic [63:0] win64;
    logic [63:0] missed64;
    logic [63:0] jitter64;
    logic [63:0] floor64;
    logic [47:0] retry48;
    logic [47:0] period48;
    logic        due;
    logic        forced;
    e = sessions[w.slot];
    due = 1'b0;
    forced = 1'b0;
    case (kind)
      KIND_TIME: begin
        win64 = 64'(e.peer_window);
        missed64 = 64'(cfg_shadow.missed);
        jitter64 = 64'(cfg_shadow.jitter);
        floor64 = 64'(cfg_shadow.floor_ms);
        limit = win64 * missed64 + jitter64;
        if (limit < floor64) limit = floor64;
        since = w.now_ms - e.last_reply_time;
        if (e.mode == MODE_BONDED && {16'd0, since} >= limit) begin
          e.mode = MODE_IDLE;
          e.peer_window = '0;
          e.tx_counter = '0;
          e.rx_counter = '0;
          e.rx_stamp = '0;
          e.rebonds_seen = e.rebonds_seen + 32'd1;
          forced = 1'b1;
        end
        if (e.mode == MODE_BONDING) begin
          since = w.now_ms - e.last_bond_time;
          retry48 = 48'(cfg_shadow.bond_retry);
          due = (since >= retry48);
        end else if (e.mode == MODE_IDLE) begin
          due = 1'b1;
        end else begin
          since = w.now_ms - e.last_send_time;
          period48 = 48'(clamped_period(e.peer_window));
          due = (since >= period48);
        end
      end
      KIND_SEND: begin
        if (w.send_ok) begin
          e.tx_counter = e.tx_counter + 32'd1;
          e.last_send_time = w.now_ms;
          if (e.mode == MODE_IDLE) begin
            e.mode = MODE_BONDING;
            e.last_bond_time = w.now_ms;
          end else if (e.mode == MODE_BONDING) begin
            e.last_bond_time = w.now_ms;
          end
        end else begin
          e.failures_seen = e.failures_seen + 32'd1;
        end
      end
      KIND_REPLY: begin
        if (w.source_match && w.checksum_ok) begin
          e.rx_counter = w.reply_counter;
          e.rx_stamp = w.reply_stamp;
          e.last_reply_time = w.now_ms;
          e.reply_type = w.reply_message;
          e.replies_seen = e.replies_seen + 32'd1;
          if (w.reply_window_ms != 16'd0) e.peer_window = w.reply_window_ms;
          e.mode = MODE_BONDED;
        end
      end
      default: begin
      end
    endcase
    sessions[w.slot] = e;
    r = '0;
    r.session_state = e.mode;
    r.send_due = due;
    r.message_type = (e.mode == MODE_BONDED) ? w.verdict : cfg_shadow.bond_code;
    r.next_counter = e.tx_counter + 32'd1;
    r.ack_counter = e.rx_counter;
    r.ack_stamp = e.rx_stamp;
    r.send_period_ms = clamped_period(e.peer_window);
    r.rebonded = forced;
    r.last_message = e.reply_type;
    r.reply_count = e.replies_seen;
    r.send_fail_count = e.failures_seen;
    r.rebond_count = e.rebonds_seen;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive
    event_t nxt;
    out_word_t rep;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rep = advance_session(in_tuser, in_word_t'(in_tdata));
        session_reports.push_back(rep);
        words_sent++;
        if (rep.rebonded) rebonds_expected++;
        if (rep.send_due) dues_expected++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (event_words.size() != 0) begin
          nxt = event_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.word;
          in_tuser <= nxt.kind;
          in_gap <= steady ? 0 : $urandom_range(0, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    out_word_t act;
    out_word_t exp;
    int s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      s = out_stall;
      if (out_tvalid && out_tready) begin
        act = out_tdata;
        reports_checked++;
        if (session_reports.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %0h", $time, act);
          errors++;
        end else begin
          exp = session_reports.pop_front();
          check_field("session_state", 64'(exp.session_state), 64'(act.session_state));
          check_field("send_due", 64'(exp.send_due), 64'(act.send_due));
          check_field("message_type", 64'(exp.message_type), 64'(act.message_type));
          check_field("next_counter", 64'(exp.next_counter), 64'(act.next_counter));
          check_field("ack_counter", 64'(exp.ack_counter), 64'(act.ack_counter));
          check_field("ack_stamp", 64'(exp.ack_stamp), 64'(act.ack_stamp));
          check_field("send_period_ms", 64'(exp.send_period_ms),
                      64'(act.send_period_ms));
          check_field("rebonded", 64'(exp.rebonded), 64'(act.rebonded));
          check_field("last_message", 64'(exp.last_message), 64'(act.last_message));
          check_field("reply_count", 64'(exp.reply_count), 64'(act.reply_count));
          check_field("send_fail_count", 64'(exp.send_fail_count),
                      64'(act.send_fail_count));
          check_field("rebond_count", 64'(exp.rebond_count), 64'(act.rebond_count));
        end
        s = steady ? 0 : $urandom_range(0, 7);
      end
      if (s > 0) begin
        out_tready <= 1'b0;
        out_stall <= s - 1;
      end else begin
        out_tready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stalled_cycles, session_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] kind, input in_word_t w);
    event_t ev;
    ev.kind = kind;
    ev.word = w;
    event_words.push_back(ev);
  endtask

  // flags are send_ok, source_match, checksum_ok
  task automatic queue_item(input logic [1:0] kind, input logic [1:0] slot,
                            input logic [47:0] now, input logic [2:0] flags,
                            input logic [15:0] win);
    in_word_t w;
    w = '0;
    w.slot = slot;
    w.now_ms = now;
    w.verdict = 8'($urandom);
    w.send_ok = flags[2];
    w.source_match = flags[1];
    w.checksum_ok = flags[0];
    w.reply_counter = $urandom;
    w.reply_stamp = $urandom;
    w.reply_message = 8'($urandom);
    w.reply_window_ms = win;
    push_word(kind, w);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MIN_PERIOD: cfg_shadow.min_period = val[15:0];
      CFG_MAX_PERIOD: cfg_shadow.max_period = val[15:0];
      CFG_BOND_RETRY: cfg_shadow.bond_retry = val[15:0];
      CFG_MISSED:     cfg_shadow.missed = val[7:0];
      CFG_JITTER:     cfg_shadow.jitter = val[15:0];
      CFG_FLOOR:      cfg_shadow.floor_ms = val[19:0];
      CFG_BOND_CODE:  cfg_shadow.bond_code = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_MIN_PERIOD, CFG_DATA_W'(c.min_period));
    write_reg(CFG_MAX_PERIOD, CFG_DATA_W'(c.max_period));
    write_reg(CFG_BOND_RETRY, CFG_DATA_W'(c.bond_retry));
    write_reg(CFG_MISSED, CFG_DATA_W'(c.missed));
    write_reg(CFG_JITTER, CFG_DATA_W'(c.jitter));
    write_reg(CFG_FLOOR, c.floor_ms);
    write_reg(CFG_BOND_CODE, CFG_DATA_W'(c.bond_code));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (event_words.size() != 0 || in_tvalid || session_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int pick;
    logic [1:0] kind;
    logic [47:0] now;
    logic [2:0] flags;
    logic [15:0] win;
    logic [63:0] wide;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = KIND_TIME;
      else if (pick < 65) kind = KIND_SEND;
      else if (pick < 94) kind = KIND_REPLY;
      else kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        clock_ms = clock_ms + 48'($urandom_range(0, 600));
        now = clock_ms;
      end else if (pick < 92) begin
        clock_ms = clock_ms + 48'($urandom_range(1000, 300000));
        now = clock_ms;
      end else if (pick < 97) begin
        clock_ms = clock_ms + 48'($urandom_range(0, 20000000));
        now = clock_ms;
      end else begin
        // out-of-order stamp, leaves the running clock alone
        wide = {$urandom, $urandom};
        now = wide[47:0];
      end
      flags[2] = ($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 99) < 85) flags[1:0] = 2'b11;
      else flags[1:0] = 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (pick < 2) win = 16'd0;
      else if (pick < 7) win = 16'($urandom_range(1, 3000));
      else win = 16'($urandom);
      queue_item(kind, 2'($urandom_range(0, MAX_SESSIONS - 1)), now, flags, win);
    end
  endtask

  task automatic run_directed();
    in_word_t w;
    // idle slot always due, then a failed and a good send
    queue_item(KIND_TIME, 2'd0, 48'd0, 3'b000, 16'd0);
    queue_item(KIND_SEND, 2'd0, 48'd10, 3'b011, 16'd0);
    queue_item(KIND_SEND, 2'd0, 48'd20, 3'b100, 16'd0);
    // bond retry boundary
    queue_item(KIND_TIME, 2'd0, 48'd519, 3'b000, 16'd0);
    queue_item(KIND_TIME, 2'd0, 48'd520, 3'b000, 16'd0);
    // replies failing source or checksum are dropped
    queue_item(KIND_REPLY, 2'd0, 48'd600, 3'b101, 16'd400);
    queue_item(KIND_REPLY, 2'd0, 48'd600, 3'b110, 16'd400);
    // zero window keeps the minimum period
    queue_item(KIND_REPLY, 2'd0, 48'd700, 3'b011, 16'd0);
    queue_item(KIND_TIME, 2'd0, 48'd769, 3'b000, 16'd0);
    queue_item(KIND_SEND, 2'd0, 48'd800, 3'b100, 16'd0);
    queue_item(KIND_TIME, 2'd0, 48'd849, 3'b000, 16'd0);
    queue_item(KIND_TIME, 2'd0, 48'd850, 3'b000, 16'd0);
    // idle slot bonds straight from a reply with the verdict and every reply field at its top
    w = '0;
    w.slot = 2'd1;
    w.now_ms = 48'd1000;
    w.verdict = 8'hFF;
    w.send_ok = 1'b1;
    w.source_match = 1'b1;
    w.checksum_ok = 1'b1;
    w.reply_counter = 32'hFFFF_FFFF;
    w.reply_stamp = 32'hFFFF_FFFF;
    w.reply_message = 8'hFF;
    w.reply_window_ms = 16'hFFFF;
    push_word(KIND_REPLY, w);
    // silence limit boundary: 65535 * 3 + 100
    queue_item(KIND_TIME, 2'd1, 48'd1000 + 48'd196704, 3'b000, 16'd0);
    queue_item(KIND_TIME, 2'd1, 48'd1000 + 48'd196705, 3'b000, 16'd0);
    queue_item(KIND_SEND, 2'd1, 48'd197000, 3'b000, 16'd0);
    // time wraps at 48 bits, window of one clamps up to the minimum
    queue_item(KIND_REPLY, 2'd2, WRAP_TOP - 48'd9, 3'b011, 16'd1);
    queue_item(KIND_TIME, 2'd2, 48'd5, 3'b000, 16'd0);
    queue_item(KIND_TIME, 2'd2, WRAP_TOP, 3'b000, 16'd0);
    // unused kind leaves the slot alone
    queue_item(KIND_SPARE, 2'd3, WRAP_TOP, 3'b111, 16'hFFFF);
    // reply that is all zero apart from its check flags, then a bonded time check with the top verdict
    w = '0;
    w.slot = 2'd3;
    w.source_match = 1'b1;
    w.checksum_ok = 1'b1;
    push_word(KIND_REPLY, w);
    w = '0;
    w.slot = 2'd3;
    w.now_ms = 48'd40;
    w.verdict = 8'hFF;
    push_word(KIND_TIME, w);
  endtask

  initial begin : stimulus
    cfg_t setting;
    cfg_shadow = '{16'd50, 16'd1000, 16'd500, 8'd3, 16'd100, 20'd1000, 8'd1};
    for (int i = 0; i < MAX_SESSIONS; i++) sessions[i] = '0;
    clock_ms = WRAP_TOP - 48'd5000000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(40);
    wait_drained();

    // min period and bond retry at one, every other register at its top
    apply_settings('{16'd1, 16'd65535, 16'd1, 8'd255, 16'd65535, 20'hFFFFF, 8'hFF});
    run_random(110);
    wait_drained();

    // crossed period bounds, no floor or margin, no idling on either side
    steady = 1'b1;
    apply_settings('{16'd2000, 16'd100, 16'd65535, 8'd1, 16'd0, 20'd0, 8'd0});
    run_random(110);
    wait_drained();
    steady = 1'b0;

    setting.min_period = 16'($urandom_range(1, 2000));
    setting.max_period = 16'($urandom_range(1, 4000));
    setting.bond_retry = 16'($urandom_range(1, 2000));
    setting.missed = 8'($urandom_range(1, 255));
    setting.jitter = 16'($urandom);
    setting.floor_ms = 20'($urandom);
    setting.bond_code = 8'($urandom);
    apply_settings(setting);
    run_random(110);
    wait_drained();

    apply_settings('{16'd50, 16'd1000, 16'd500, 8'd3, 16'd100, 20'd1000, 8'd1});
    run_random(110);
    wait_drained();

    $display("%0d words under %0d register settings, %0d results compared",
             words_sent, settings_applied, reports_checked);
    $display("%0d frames due and %0d forced re-bonds predicted, %0d mismatches",
             dues_expected, rebonds_expected, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hbls_pkg.sv
rtl/hbls_state_mem.sv
rtl/heartbeat_link_session_core.sv
verif/testbench.sv
